>>> rtl/alle_pkg.sv
// Package with the beat types, request and status codes, and sequencer states of the list engine.
package alle_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_VISIT  = 2'd1;
  localparam logic [1:0] REQ_ROTATE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] ROT_STEPS = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_VIS_RD,
    S_VIS_EMIT,
    S_ROT_WALK_RD,
    S_ROT_WALK_CHK,
    S_ROT_TERM,
    S_ROT_A,
    S_ROT_B,
    S_ROT_C,
    S_RESP
  } state_t;

endpackage

>>> rtl/array_linked_list_engine.sv
// Top level of the linked list engine: node stores, link walker and result register.
//
// The block keeps a singly linked list of up to CAPACITY 32-bit values in a node
// store, with the unused nodes chained on a free list through the same link memory.
// Requests arrive as beats on the in_ channel (valid/ready). An insert request
// pushes new_value at the head and returns one beat with status OK or FULL. A visit
// request returns one beat per stored value, head first, with last_of_run set on
// the final one; an empty list gives a single EMPTY beat. A rotate request walks to
// the tail, rotates the list left by three, and returns one OK beat. Request code 3
// is taken and dropped without any result.
// One request is worked on at a time and in_ready is low until its last result has
// been loaded into the output register. All work goes through one read port of the
// link and value memories, one node at a time: an insert reads the free node and then
// links it in, a visit reads each node and then emits its value, and a rotate walks
// the whole list before it moves the head node behind the tail three times.
// The result register frees the request side: a new request is accepted while the
// last result still waits; a stalled out_ready holds the beat and pauses the walk.
// Reset (rst_n low, synchronous) empties the list and threads all nodes onto the
// free list at once, with no clearing pass; stored values stay undefined until written.
module array_linked_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  alle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output alle_pkg::out_item_t out_data
);
  import alle_pkg::*;

  // Node indexes carry one extra code, CAPACITY, that ends either list.
  localparam int IDX_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         rot_r, rot_nxt;
  logic [1:0]         st_r, st_nxt;
  logic signed [31:0] val_r, val_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Memories. Every read and write goes to the node that ptr_r names.
  logic [IDX_W-1:0]   link_mem [CAPACITY];
  logic signed [31:0] val_mem  [CAPACITY];
  logic [CAPACITY-1:0] link_vld_r;
  logic [IDX_W-1:0]   link_q_r;
  logic               link_vq_r;
  logic [IDX_W-1:0]   addr_q_r;
  logic signed [31:0] val_q_r;

  logic [ADDR_W-1:0]  rd_idx;
  logic [IDX_W-1:0]   link_out;
  logic               lw_en;
  logic [IDX_W-1:0]   lw_data;
  logic               vw_en;
  logic               out_free;
  logic               nx_valid;

  function automatic logic is_node(input logic [IDX_W-1:0] idx);
    return idx < END_IDX;
  endfunction

  assign rd_idx = ptr_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[rd_idx] <= lw_data;
    end
    if (vw_en) begin
      val_mem[rd_idx] <= val_r;
    end
    link_q_r  <= link_mem[rd_idx];
    val_q_r   <= val_mem[rd_idx];
    link_vq_r <= link_vld_r[rd_idx];
    addr_q_r  <= ptr_r;
  end

  // A link that was never written since reset reads as its reset value, the next node.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (lw_en) begin
      link_vld_r[rd_idx] <= 1'b1;
    end
  end

  assign link_out = link_vq_r ? link_q_r : IDX_W'(addr_q_r + 1'b1);
  assign nx_valid = is_node(link_out);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= END_IDX;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    cnt_r      <= cnt_nxt;
    rot_r      <= rot_nxt;
    st_r       <= st_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    rot_nxt       = rot_r;
    st_nxt        = st_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    lw_en         = 1'b0;
    lw_data       = END_IDX;
    vw_en         = 1'b0;
    in_ready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt = in_data.new_value;
          case (in_data.req_type)
            REQ_INSERT: begin
              if (is_node(free_r)) begin
                ptr_nxt   = free_r;
                state_nxt = S_INS_RD;
              end else begin
                st_nxt    = ST_FULL;
                state_nxt = S_RESP;
              end
            end
            REQ_VISIT: begin
              if (is_node(head_r)) begin
                ptr_nxt   = head_r;
                cnt_nxt   = '0;
                state_nxt = S_VIS_RD;
              end else begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end
            end
            REQ_ROTATE: begin
              st_nxt = ST_OK;
              if (is_node(head_r)) begin
                ptr_nxt   = head_r;
                cnt_nxt   = '0;
                state_nxt = S_ROT_WALK_RD;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end

      // The free node's link becomes the new free head; the node joins the list head.
      S_INS_WR: begin
        vw_en     = 1'b1;
        lw_en     = 1'b1;
        lw_data   = head_r;
        free_nxt  = link_out;
        head_nxt  = ptr_r;
        st_nxt    = ST_OK;
        state_nxt = S_RESP;
      end

      S_VIS_RD: begin
        state_nxt = S_VIS_EMIT;
      end

      S_VIS_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.item_value  = val_q_r;
          out_data_nxt.last_of_run = !nx_valid || (cnt_r == CNT_LAST);
          if (!nx_valid || (cnt_r == CNT_LAST)) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = link_out;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_VIS_RD;
          end
        end
      end

      S_ROT_WALK_RD: begin
        state_nxt = S_ROT_WALK_CHK;
      end

      S_ROT_WALK_CHK: begin
        if (!nx_valid) begin
          state_nxt = S_ROT_TERM;
        end else begin
          ptr_nxt   = link_out;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = (cnt_r == CNT_LAST) ? S_ROT_TERM : S_ROT_WALK_RD;
        end
      end

      // Close the tail, then move the head node behind it three times.
      S_ROT_TERM: begin
        lw_en     = 1'b1;
        lw_data   = END_IDX;
        rot_nxt   = '0;
        state_nxt = S_ROT_A;
      end

      S_ROT_A: begin
        if ((rot_r == ROT_STEPS) || !is_node(head_r)) begin
          state_nxt = S_RESP;
        end else begin
          lw_en     = 1'b1;
          lw_data   = head_r;
          ptr_nxt   = head_r;
          state_nxt = S_ROT_B;
        end
      end

      S_ROT_B: begin
        state_nxt = S_ROT_C;
      end

      S_ROT_C: begin
        lw_en     = 1'b1;
        lw_data   = END_IDX;
        head_nxt  = nx_valid ? link_out : END_IDX;
        rot_nxt   = rot_r + 1'b1;
        state_nxt = S_ROT_A;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = st_r;
          out_data_nxt.item_value  = '0;
          out_data_nxt.last_of_run = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> bench/tb_array_linked_list_engine.sv
// Self-checking testbench for the linked list engine: stimulus queue, driver, predictor, monitor.
`timescale 1ns / 1ps

module tb_array_linked_list_engine;
  import alle_pkg::*;

  // Size of the node store in the block and in the predictor.
  localparam int NODES = 16;
  // A link that holds NODES ends a list; it fits in the five link bits.
  localparam logic [4:0] END_LINK = 5'd16;
  // Request code that the block takes and drops.
  localparam logic [1:0] REQ_DROPPED = 2'd3;
  // Random requests that produce at least one beat.
  localparam int RANDOM_REQS = 480;
  // Once this few requests remain, neither side starts a new idle burst.
  localparam int QUIET_TAIL = 60;
  // Cycles without any accepted beat before the run is declared hung.
  // The slowest legal gap is a full-list rotate behind a sender idle burst
  // and a result stall, so this is ample.
  localparam int HANG_LIMIT = 2000;
  // Settling time after the last expected beat, to catch stray results.
  localparam int DRAIN_CYCLES = 64;
  // Mismatch lines printed before further ones are only counted.
  localparam int PRINT_LIMIT = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  array_linked_list_engine #(.CAPACITY(NODES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns period: high for 2 ns, low for 2 ns.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Requests waiting to be driven, and result beats waiting to be seen.
  in_item_t  req_backlog[$];
  out_item_t due_beats[$];
  int        fail_count = 0;

  // The predictor's own copy of the node store, list heads and free list.
  logic [31:0] node_val[NODES];
  logic [4:0]  node_nxt[NODES];
  logic [4:0]  head_ptr;
  logic [4:0]  free_ptr;

  function automatic out_item_t make_beat(logic [1:0] st, logic [31:0] val, logic last);
    out_item_t b;
    b.status      = st;
    b.item_value  = val;
    b.last_of_run = last;
    return b;
  endfunction

  // Applies one accepted request to the list copy and queues the beats it
  // must cause, in order.
  function automatic void apply_list_request(in_item_t req);
    int          n;
    int          p;
    int          k;
    int          steps;
    logic [4:0]  nx;
    logic [4:0]  tail;
    logic [4:0]  h;
    logic [4:0]  nh;
    case (req.req_type)
      REQ_INSERT: begin
        if (free_ptr >= END_LINK) begin
          due_beats.push_back(make_beat(ST_FULL, 32'd0, 1'b1));
        end else begin
          // Pop the free list and push the node at the head of the list.
          n = int'(free_ptr);
          free_ptr = node_nxt[n];
          node_val[n] = req.new_value;
          node_nxt[n] = head_ptr;
          head_ptr = n[4:0];
          due_beats.push_back(make_beat(ST_OK, 32'd0, 1'b1));
        end
      end
      REQ_VISIT: begin
        if (head_ptr >= END_LINK) begin
          due_beats.push_back(make_beat(ST_EMPTY, 32'd0, 1'b1));
        end else begin
          // One beat per node, head first; the walk is bounded by the store size.
          p = int'(head_ptr);
          k = 0;
          while (p < NODES && k < NODES) begin
            nx = node_nxt[p];
            due_beats.push_back(make_beat(ST_OK, node_val[p],
                                          (nx >= END_LINK) || (k + 1 >= NODES)));
            k++;
            p = int'(nx);
          end
        end
      end
      REQ_ROTATE: begin
        if (head_ptr < END_LINK) begin
          // Find the tail, close it off, then move the head to the tail three times.
          tail = head_ptr;
          steps = 0;
          while (steps < NODES) begin
            nx = node_nxt[tail];
            if (nx >= END_LINK) break;
            tail = nx;
            steps++;
          end
          node_nxt[tail] = END_LINK;
          for (int r = 0; r < int'(ROT_STEPS); r++) begin
            h = head_ptr;
            if (h < END_LINK && tail < END_LINK) begin
              node_nxt[tail] = h;
              nh = node_nxt[h];
              node_nxt[h] = END_LINK;
              head_ptr = (nh < END_LINK) ? nh : END_LINK;
              tail = h;
            end
          end
        end
        due_beats.push_back(make_beat(ST_OK, 32'd0, 1'b1));
      end
      default: begin
        // The unused code is taken and dropped: no beat, no state change.
      end
    endcase
  endfunction

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  task automatic queue_request(logic [1:0] code, logic [31:0] val);
    in_item_t r;
    r.req_type  = code;
    r.new_value = val;
    req_backlog.push_back(r);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Driver. A new request beat is presented only when the channel is free
  // after this edge, either because nothing was offered or because the
  // current beat is being accepted now. Idle bursts are inserted at random
  // until the quiet tail of the run.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        apply_list_request(in_data);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          // This cycle is the first of the burst.
          in_gap = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted result beat is compared field by field with the
  // oldest expected beat. out_ready drops in random bursts, which holds the
  // beat in the result register and pauses the block's walk.
  int        out_gap = 0;
  out_item_t want_beat;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_beats.size() == 0) begin
          report_mismatch("unexpected beat", out_data.item_value, 32'd0);
        end else begin
          want_beat = due_beats.pop_front();
          if (out_data.status !== want_beat.status)
            report_mismatch("status", 32'(out_data.status), 32'(want_beat.status));
          if (out_data.item_value !== want_beat.item_value)
            report_mismatch("item_value", out_data.item_value, want_beat.item_value);
          if (out_data.last_of_run !== want_beat.last_of_run)
            report_mismatch("last_of_run", 32'(out_data.last_of_run),
                            32'(want_beat.last_of_run));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (req_backlog.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[%0t] timeout: no beat for %0d cycles, %0d beats outstanding",
                 $realtime, HANG_LIMIT, due_beats.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Builds the request list, runs reset once, then waits for the drain.
  initial begin
    int  issued;
    int  pick;
    logic [1:0] code;

    // The predictor starts where reset leaves the block: empty list, every
    // node on the free list in index order.
    for (int i = 0; i < NODES; i++) begin
      node_val[i] = 32'd0;
      node_nxt[i] = 5'(i + 1);
    end
    head_ptr = END_LINK;
    free_ptr = 5'd0;

    // Directed part: empty list cases, the dropped code, value extremes,
    // and rotates over lists of one, two and four nodes.
    queue_request(REQ_VISIT, 32'h1234_5678);
    queue_request(REQ_ROTATE, 32'hFFFF_FFFF);
    queue_request(REQ_DROPPED, 32'hFFFF_FFFF);
    queue_request(REQ_INSERT, 32'h8000_0000);
    queue_request(REQ_VISIT, 32'd0);
    queue_request(REQ_ROTATE, 32'd0);
    queue_request(REQ_VISIT, 32'd0);
    queue_request(REQ_INSERT, 32'h7FFF_FFFF);
    queue_request(REQ_ROTATE, 32'd0);
    queue_request(REQ_VISIT, 32'd0);
    queue_request(REQ_INSERT, 32'h0000_0000);
    queue_request(REQ_INSERT, 32'hFFFF_FFFF);
    queue_request(REQ_VISIT, 32'd0);
    queue_request(REQ_ROTATE, 32'hA5A5_A5A5);
    queue_request(REQ_VISIT, 32'd0);
    queue_request(REQ_ROTATE, 32'd0);
    queue_request(REQ_VISIT, 32'h5A5A_5A5A);
    queue_request(REQ_DROPPED, 32'h0000_0000);

    // Random part. Inserts are frequent so the store fills early; after that
    // inserts report full, and visits of the whole store and rotates dominate.
    issued = 0;
    while (issued < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)       code = REQ_INSERT;
      else if (pick < 70)  code = REQ_VISIT;
      else if (pick < 95)  code = REQ_ROTATE;
      else                 code = REQ_DROPPED;
      queue_request(code, pick_value());
      if (code != REQ_DROPPED) issued++;
    end

    // Synchronous reset held low, then released.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request has been taken and every beat has come back.
    while (req_backlog.size() != 0 || in_valid || due_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && due_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
